// ----- hdl/isc_pkg.sv -----
`timescale 1ns / 1ps

package isc_pkg;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd16;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [3:0]        vertex_a;
    logic [3:0]        vertex_b;
    logic [15:0]       query_set;
  } in_t;

  typedef struct packed {
    logic is_independent;
    logic is_maximal;
    logic bad_vertex;
  } out_t;

  // request from the control sequencer to the row store
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [VIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [VIDX_W-1:0] wr_addr;
    row_t              wr_data;
  } mem_req_t;

  // bit i set for every vertex below the active count
  function automatic row_t keep_mask(input logic [CNT_W-1:0] cnt);
    row_t m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (CNT_W'(i) < cnt);
    end
    return m;
  endfunction

endpackage

// ----- hdl/isc_row_mem.sv -----
`timescale 1ns / 1ps

module isc_row_mem import isc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output row_t     rd_row_o
);

  row_t                    mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  row_t                    rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // a row never written since the last clear reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hdl/independent_set_checker.sv -----
`timescale 1ns / 1ps

// Independent-set checker over a graph of up to 16 vertices, one adjacency row
// per vertex in a single-port-read synchronous memory. Every input transfer
// gives exactly one result transfer. A query reads one row per cycle; an
// add-edge is a read-modify-write of two rows; clear, unused kinds and a
// rejected edge go straight to the result. The result sits in an output
// register, so the next item is accepted while a finished result still waits,
// but that item's result is held back, and the input stays stalled, until the
// waiting result has been taken. Clearing uses per-row valid flags. The user
// must write the vertex count register by cfg_we_i only while the block is
// idle; the block itself does not enforce this.
module independent_set_checker import isc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_Q_RUN,
    ST_RESP
  } state_e;

  state_e            state_q;
  logic [CFG_W-1:0]  vcount_q;
  in_t               item_q;
  row_t              set_q;
  logic [CNT_W-1:0]  idx_q;
  logic              rd_pend_q;
  logic [VIDX_W-1:0] rd_idx_q;
  logic              ok_q;
  logic              full_q;
  out_t              res_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic [CNT_W-1:0]  cnt;
  row_t              keep;
  mem_req_t          mem_req;
  row_t              rd_row;
  logic              issue;
  logic              bad_edge;
  row_t              row_k;
  row_t              own_bit;
  logic              in_set;
  logic              hit;
  logic              empty;
  logic              res_load;

  assign cnt  = (vcount_q > CFG_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                  : CNT_W'(vcount_q);
  assign keep = keep_mask(cnt);

  assign issue    = (state_q == ST_Q_RUN) && (idx_q < cnt);
  assign bad_edge = ({1'b0, in_data_i.vertex_a} >= cnt) ||
                    ({1'b0, in_data_i.vertex_b} >= cnt);

  // result moves into the output register once that register is free
  assign res_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // row check for the row returned this cycle
  assign row_k   = rd_row & keep;
  assign own_bit = row_t'(1) << rd_idx_q;
  assign in_set  = set_q[rd_idx_q];
  assign hit     = |(row_k & set_q);
  assign empty   = ~|(row_k & (set_q | own_bit));

  always_comb begin
    mem_req         = '0;
    mem_req.clr     = (state_q == ST_IDLE) && in_valid_i &&
                      (in_data_i.kind == KIND_CLEAR);
    mem_req.rd_en   = issue || (state_q == ST_ADD_RD_A) || (state_q == ST_ADD_RD_B);
    mem_req.wr_en   = (state_q == ST_ADD_WR_A) || (state_q == ST_ADD_WR_B);
    mem_req.wr_addr = (state_q == ST_ADD_WR_A) ? item_q.vertex_a : item_q.vertex_b;
    mem_req.wr_data = rd_row | ((state_q == ST_ADD_WR_A) ? (row_t'(1) << item_q.vertex_b)
                                                         : (row_t'(1) << item_q.vertex_a));
    unique case (state_q)
      ST_Q_RUN:    mem_req.rd_addr = idx_q[VIDX_W-1:0];
      ST_ADD_RD_A: mem_req.rd_addr = item_q.vertex_a;
      default:     mem_req.rd_addr = item_q.vertex_b;
    endcase
  end

  isc_row_mem u_row_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rd_row_o(rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= VCOUNT_RESET;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      ok_q        <= 1'b0;
      full_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      set_q       <= '0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_data_q  <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            // only a rejected edge flags anything before the work is done
            res_q  <= '{is_independent: 1'b0, is_maximal: 1'b0,
                        bad_vertex: (in_data_i.kind == KIND_ADD) && bad_edge};
            unique case (in_data_i.kind)
              KIND_CLEAR: state_q <= ST_RESP;
              KIND_ADD: begin
                if (bad_edge) begin
                  state_q <= ST_RESP;
                end else begin
                  state_q <= ST_ADD_RD_A;
                end
              end
              KIND_QUERY: begin
                set_q     <= in_data_i.query_set[MAX_VERTICES-1:0] & keep;
                ok_q      <= 1'b1;
                full_q    <= 1'b1;
                idx_q     <= '0;
                rd_pend_q <= 1'b0;
                state_q   <= ST_Q_RUN;
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_ADD_RD_A: state_q <= ST_ADD_WR_A;
        ST_ADD_WR_A: state_q <= ST_ADD_RD_B;
        ST_ADD_RD_B: state_q <= ST_ADD_WR_B;
        ST_ADD_WR_B: state_q <= ST_RESP;
        ST_Q_RUN: begin
          rd_pend_q <= issue;
          if (issue) begin
            rd_idx_q <= idx_q[VIDX_W-1:0];
            idx_q    <= idx_q + CNT_W'(1);
          end
          if (rd_pend_q) begin
            if (in_set && hit) begin
              ok_q <= 1'b0;
            end
            if (!in_set && empty) begin
              full_q <= 1'b0;
            end
          end
          if (!issue && !rd_pend_q) begin
            res_q   <= '{is_independent: ok_q, is_maximal: ok_q & full_q,
                         bad_vertex: 1'b0};
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (res_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_maximal_implies_indep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.is_maximal || out_data_o.is_independent))
    else $error("maximal result without independence");

  a_bad_only_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_vertex |->
      (!out_data_o.is_independent && !out_data_o.is_maximal))
    else $error("bad vertex flag mixed with query result");

  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RUN) |-> (idx_q <= cnt))
    else $error("row index ran past the vertex count");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted item did not start work");

  a_write_only_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> ($past(state_q) == ST_ADD_RD_A || $past(state_q) == ST_ADD_RD_B))
    else $error("row write without a preceding row read");
`endif

endmodule

// ----- sim/independent_set_checker_tb.sv -----
`timescale 1ns / 1ps

module independent_set_checker_tb;
  import isc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NUM_DIRECTED = 27;
  localparam int unsigned RANDOM_BLOCKS = 8;
  localparam int unsigned BLOCK_ITEMS = 250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned MAX_PRINTED = 50;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [CFG_W-1:0] vcount;
    in_t              item;
    bit               fixed;
    out_t             want;
  } directed_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;

  // shadow copy of the adjacency store and the vertex count
  row_t             graph_rows [MAX_VERTICES];
  logic [CFG_W-1:0] vertex_count_cfg = VCOUNT_RESET;
  out_t             pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          start_hold = 1'b0;
  logic        hold_output = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{5'd16, {KIND_QUERY,  4'h0, 4'h0, 16'h0000}, 1'b1, 3'b100},
    '{5'd16, {KIND_QUERY,  4'h0, 4'h0, 16'hFFFF}, 1'b1, 3'b110},
    '{5'd16, {KIND_UNUSED, 4'hF, 4'hF, 16'hFFFF}, 1'b1, 3'b000},
    '{5'd16, {KIND_ADD,    4'h0, 4'hF, 16'h5A5A}, 1'b1, 3'b000},
    '{5'd16, {KIND_ADD,    4'hF, 4'hF, 16'h0000}, 1'b1, 3'b000},
    '{5'd16, {KIND_QUERY,  4'h3, 4'hC, 16'h8001}, 1'b0, 3'b000},
    '{5'd16, {KIND_QUERY,  4'h0, 4'h0, 16'h8000}, 1'b0, 3'b000},
    '{5'd16, {KIND_QUERY,  4'hF, 4'h0, 16'h7FFE}, 1'b0, 3'b000},
    '{5'd16, {KIND_ADD,    4'h5, 4'h9, 16'hFFFF}, 1'b1, 3'b000},
    '{5'd16, {KIND_QUERY,  4'h0, 4'h0, 16'h0220}, 1'b0, 3'b000},
    '{5'd16, {KIND_QUERY,  4'hA, 4'h5, 16'h7DDE}, 1'b0, 3'b000},
    '{5'd16, {KIND_CLEAR,  4'hF, 4'h0, 16'hAAAA}, 1'b1, 3'b000},
    '{5'd16, {KIND_QUERY,  4'h0, 4'h0, 16'hFFFF}, 1'b1, 3'b110},
    '{5'd16, {KIND_ADD,    4'h1, 4'h2, 16'h0000}, 1'b1, 3'b000},
    '{5'd16, {KIND_ADD,    4'h2, 4'h3, 16'h1111}, 1'b1, 3'b000},
    '{5'd4,  {KIND_ADD,    4'hF, 4'h1, 16'h0000}, 1'b1, 3'b001},
    '{5'd4,  {KIND_ADD,    4'h1, 4'h4, 16'h0000}, 1'b1, 3'b001},
    '{5'd4,  {KIND_ADD,    4'h3, 4'h0, 16'h0000}, 1'b1, 3'b000},
    '{5'd4,  {KIND_QUERY,  4'h0, 4'h0, 16'hFFF5}, 1'b0, 3'b000},
    '{5'd4,  {KIND_QUERY,  4'h0, 4'h0, 16'h000A}, 1'b0, 3'b000},
    '{5'd0,  {KIND_ADD,    4'h0, 4'h0, 16'h0000}, 1'b1, 3'b001},
    '{5'd0,  {KIND_QUERY,  4'h0, 4'h0, 16'h1234}, 1'b1, 3'b110},
    '{5'd31, {KIND_QUERY,  4'h0, 4'h0, 16'hFFFF}, 1'b0, 3'b000},
    '{5'd31, {KIND_ADD,    4'hF, 4'hE, 16'h0000}, 1'b1, 3'b000},
    '{5'd31, {KIND_QUERY,  4'h0, 4'h0, 16'h4000}, 1'b0, 3'b000},
    '{5'd1,  {KIND_ADD,    4'h0, 4'h1, 16'h0000}, 1'b1, 3'b001},
    '{5'd1,  {KIND_QUERY,  4'h0, 4'h0, 16'h0001}, 1'b0, 3'b000}
  };

  independent_set_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("FAIL independent_set_checker");
    $finish;
  end

  function automatic int unsigned active_vertices();
    return (vertex_count_cfg < MAX_VERTICES) ? vertex_count_cfg : MAX_VERTICES;
  endfunction

  // applies one item to the shadow graph and returns the answer it gets
  function automatic out_t predict_answer(input in_t item);
    int unsigned cnt;
    row_t        keep;
    row_t        set;
    row_t        row;
    logic        ok;
    logic        full;
    out_t        r;
    cnt = active_vertices();
    keep = row_t'((33'h1 << cnt) - 1);
    r = '0;
    case (item.kind)
      KIND_CLEAR: begin
        for (int i = 0; i < MAX_VERTICES; i++) graph_rows[i] = '0;
      end
      KIND_ADD: begin
        if (item.vertex_a >= cnt || item.vertex_b >= cnt) begin
          r.bad_vertex = 1'b1;
        end else begin
          graph_rows[item.vertex_a][item.vertex_b] = 1'b1;
          graph_rows[item.vertex_b][item.vertex_a] = 1'b1;
        end
      end
      KIND_QUERY: begin
        set = item.query_set & keep;
        ok = 1'b1;
        full = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          row = graph_rows[i] & keep;
          if (set[i]) begin
            if ((row & set) != '0) ok = 1'b0;
          end else if ((row & (set | (row_t'(1) << i))) == '0) begin
            // an outside vertex with no neighbor in the set could still join
            full = 1'b0;
          end
        end
        r.is_independent = ok;
        r.is_maximal = ok & full;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned cnt;
    int unsigned pick;
    int unsigned start;
    int unsigned v;
    int unsigned flip;
    row_t        keep;
    row_t        set;
    cnt = active_vertices();
    keep = row_t'((33'h1 << cnt) - 1);
    it.kind = KIND_QUERY;
    it.vertex_a = 4'($urandom);
    it.vertex_b = 4'($urandom);
    it.query_set = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 7) begin
      it.kind = KIND_UNUSED;
    end else if (pick < 42) begin
      it.kind = KIND_ADD;
      if (cnt > 0 && $urandom_range(9) != 0) begin
        it.vertex_a = 4'($urandom_range(cnt - 1));
        it.vertex_b = 4'($urandom_range(cnt - 1));
      end
    end else if (pick < 70) begin
      // greedy maximal set from a random start, sometimes broken by one flip
      set = '0;
      start = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
      for (int k = 0; k < cnt; k++) begin
        v = (start + k) % cnt;
        if (!graph_rows[v][v] && (graph_rows[v] & set) == '0) set[v] = 1'b1;
      end
      if ($urandom_range(3) == 0) begin
        flip = $urandom_range(MAX_VERTICES - 1);
        set[flip] = ~set[flip];
      end
      it.query_set = set | (16'($urandom) & ~keep);
    end else if (pick < 85) begin
      it.query_set = 16'($urandom) & 16'($urandom);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input out_t got, input out_t want);
    if (mismatch_count < MAX_PRINTED) begin
      $display({"mismatch at result %0d: %0s got ind=%0b max=%0b bad=%0b",
                " want ind=%0b max=%0b bad=%0b"},
               result_count, what, got.is_independent, got.is_maximal, got.bad_vertex,
               want.is_independent, want.is_maximal, want.bad_vertex);
    end
    mismatch_count++;
  endtask

  task automatic send_item(input in_t item, input bit fixed, input out_t want);
    out_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_answer(item);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  // only while idle: all answers back, then a pause for the block to settle
  task automatic set_vertex_count(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vertex_count_cfg = value;
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 56;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        recv_stall_pct = 56;
      end
      default: begin
        sender_idle_pct = 20;
        recv_stall_pct = 20;
      end
    endcase
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= hold_output || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (start_hold);
    @(negedge clk_i);
    hold_output <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_output <= 1'b0;
  end

  always @(posedge clk_i) begin : answer_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_data_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.is_independent !== want.is_independent)
          report_mismatch("is_independent", out_data_o, want);
        if (out_data_o.is_maximal !== want.is_maximal)
          report_mismatch("is_maximal", out_data_o, want);
        if (out_data_o.bad_vertex !== want.bad_vertex)
          report_mismatch("bad_vertex", out_data_o, want);
      end
      result_count++;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] block_counts [RANDOM_BLOCKS];
    int unsigned      waited;
    block_counts = '{5'd16, 5'd6, 5'd31, 5'd2, 5'd16, 5'd9, 5'd0, 5'd0};
    block_counts[RANDOM_BLOCKS-1] = CFG_W'($urandom_range(31));
    for (int i = 0; i < MAX_VERTICES; i++) graph_rows[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idle_mode(IDLE_BOTH);
    foreach (directed_rows[k]) begin
      if (directed_rows[k].vcount != vertex_count_cfg) set_vertex_count(directed_rows[k].vcount);
      send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);
    end

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      set_vertex_count(block_counts[b]);
      set_idle_mode(idle_mode_e'(b % 4));
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (b == 0 && n == 20) start_hold = 1'b1;
        send_item(random_item(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("FAIL independent_set_checker");
    end else begin
      repeat (40) @(negedge clk_i);
      if (mismatch_count == 0) begin
        $display("PASS independent_set_checker");
      end else begin
        $display("FAIL independent_set_checker");
      end
    end
    $finish;
  end

endmodule
